>>> hw/rtl/urc_pkg.sv
// Shared constants for the ultrasonic ranging controller.
// Used by the trigger sequencer and the top level; depends on nothing.
package urc_pkg;

  localparam int STAMP_WIDTH_DEF = 32;
  localparam int TICK_W          = 16;
  localparam int CFG_IDX_W       = 8;
  localparam int ECHO_W          = 1;
  localparam int FLIGHT_W        = 16;
  localparam int DIST_W          = 14;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOW_TICKS  = CFG_IDX_W'(1);

  localparam logic [TICK_W-1:0] HIGH_TICKS_RST = TICK_W'(10);
  localparam logic [TICK_W-1:0] LOW_TICKS_RST  = TICK_W'(60000);

  localparam logic [FLIGHT_W-1:0] FLIGHT_MAX = '1;

  // distance = floor(flight * SOUND_NUM / SOUND_DEN), done as one constant
  // multiply by a rounded-up reciprocal and a shift; exact for 16-bit flight.
  localparam int SOUND_NUM  = 34;
  localparam int SOUND_DEN  = 200;
  localparam int DIST_SHIFT = 29;
  localparam int DIST_RECIP = ((2 ** DIST_SHIFT) + SOUND_DEN - 1) / SOUND_DEN;
  localparam int DIST_MUL_W = 27;
  localparam logic [DIST_MUL_W-1:0] DIST_MUL = DIST_MUL_W'(SOUND_NUM * DIST_RECIP);
  localparam int PROD_W     = FLIGHT_W + DIST_MUL_W;
  localparam logic [DIST_W-1:0] DIST_MAX = DIST_W'(11140);

endpackage

>>> hw/rtl/ultrasonic_ranging_controller_core.sv
// An accepted tick passes through the stage 1 register and the output register to
// out_*. One tick per clock cycle while out_tready is high; the input stage and the
// output register (distance multiply) form a two-deep pipeline under out_tready.
// Reset (rst_n low, synchronous): trigger low phase, counters, stamps, held
// flight and distance cleared; high_ticks = 10, low_ticks = 60000.
// Depends on urc_pkg and urc_trig_seq.
module ultrasonic_ranging_controller_core
  import urc_pkg::*;
#(
  parameter int STAMP_WIDTH = STAMP_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // tick input
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,    // [0] echo_level, [7:1] zero
  // result output
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,   // [0] trigger_out, [1] echo_done,
                                            // [17:2] flight_us, [31:18] distance_mm
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  // ---------------------------------------------------------------------
  // Configuration registers; always ready, unknown indexes are dropped.
  // ---------------------------------------------------------------------
  logic [TICK_W-1:0] high_ticks_r;
  logic [TICK_W-1:0] low_ticks_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_ticks_r <= HIGH_TICKS_RST;
      low_ticks_r  <= LOW_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_HIGH_TICKS: high_ticks_r <= cfg_data;
        REG_LOW_TICKS:  low_ticks_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: stage 1 frees whenever it moves into the output
  // register, so a tick enters every cycle while the output is taken.
  // ---------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic adv_out;
  logic in_acc;

  assign adv_out   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv_out;
  assign in_acc    = in_tvalid && in_tready;

  // ---------------------------------------------------------------------
  // Stage 1: edge detection, timestamping, saturated flight time.
  // ---------------------------------------------------------------------
  logic                   echo;
  logic                   prev_echo_r;
  logic [STAMP_WIDTH-1:0] tick_r;
  logic [STAMP_WIDTH-1:0] rise_r;
  logic [STAMP_WIDTH-1:0] diff;
  logic [FLIGHT_W-1:0]    flight_sat;
  logic                   rise_edge;
  logic                   fall_edge;
  logic                   trig_level;

  logic                   s1_trig_r;
  logic                   s1_done_r;
  logic [FLIGHT_W-1:0]    s1_flight_r;   // doubles as the held flight time

  assign echo      = in_tdata[0];
  assign rise_edge = echo && !prev_echo_r;
  assign fall_edge = !echo && prev_echo_r;
  assign diff      = tick_r - rise_r;      // wraps modulo 2^STAMP_WIDTH

  always_comb begin
    if (diff[STAMP_WIDTH-1:FLIGHT_W] != '0) begin
      flight_sat = FLIGHT_MAX;
    end else begin
      flight_sat = diff[FLIGHT_W-1:0];
    end
  end

  urc_trig_seq u_trig_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (in_acc),
    .high_ticks (high_ticks_r),
    .low_ticks  (low_ticks_r),
    .trig_level (trig_level)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      prev_echo_r <= 1'b0;
      tick_r      <= '0;
      rise_r      <= '0;
      s1_flight_r <= '0;
      s1_done_r   <= 1'b0;
      s1_trig_r   <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r  <= 1'b1;
        prev_echo_r <= echo;
        tick_r      <= tick_r + STAMP_WIDTH'(1);
        s1_trig_r   <= trig_level;
        s1_done_r   <= fall_edge;
        // Stamp the rising edge; hold flight on the falling edge.
        if (rise_edge) begin
          rise_r <= tick_r;
        end
        if (fall_edge) begin
          s1_flight_r <= flight_sat;
        end
      end else if (adv_out) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2 (output register): distance by constant reciprocal multiply.
  // The output distance register holds the latest distance between edges.
  // ---------------------------------------------------------------------
  logic [PROD_W-1:0]   dist_prod;
  logic                out_trig_r;
  logic                out_done_r;
  logic [FLIGHT_W-1:0] out_flight_r;
  logic [DIST_W-1:0]   out_dist_r;

  assign dist_prod = PROD_W'(s1_flight_r) * PROD_W'(DIST_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      out_trig_r   <= 1'b0;
      out_done_r   <= 1'b0;
      out_flight_r <= '0;
      out_dist_r   <= '0;
    end else begin
      if (adv_out) begin
        out_valid_r  <= 1'b1;
        out_trig_r   <= s1_trig_r;
        out_done_r   <= s1_done_r;
        out_flight_r <= s1_flight_r;
        if (s1_done_r) begin
          out_dist_r <= dist_prod[DIST_SHIFT +: DIST_W];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dist_r, out_flight_r, out_done_r, out_trig_r};

`ifndef ASSERT_OFF
  // A full stage 1 that cannot move on must still be full next cycle.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv_out |=> s1_valid_r)
    else $error("stage 1 transaction dropped");

  // A falling echo edge on an accepted tick marks the transaction done.
  a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && fall_edge |=> s1_done_r)
    else $error("falling edge lost");

  // A rising edge stamps the current tick time.
  a_rise_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && rise_edge |=> rise_r == $past(tick_r))
    else $error("rise stamp wrong");

  // Distance never exceeds the value for a saturated flight time.
  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_dist_r <= DIST_MAX)
    else $error("distance out of range");

  // Input is only refused while stage 1 is full.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r && out_valid_r)
    else $error("input refused with room");
`endif

endmodule

>>> hw/rtl/urc_trig_seq.sv
// Two-phase trigger sequencer: high for high_ticks, low for low_ticks.
// Depends on urc_pkg.
module urc_trig_seq
  import urc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,        // advance one tick
  input  logic [TICK_W-1:0] high_ticks,
  input  logic [TICK_W-1:0] low_ticks,
  output logic              trig_level   // phase before this tick advances
);

  logic              phase_r, phase_nxt;
  logic [TICK_W-1:0] count_r, count_nxt;
  logic [TICK_W-1:0] len;
  logic [TICK_W-1:0] count_inc;

  always_comb begin
    len = phase_r ? high_ticks : low_ticks;
    if (len == '0) begin
      len = TICK_W'(1);
    end
    count_inc = count_r + TICK_W'(1);
    phase_nxt = phase_r;
    count_nxt = count_inc;
    if (count_inc >= len || count_inc == '0) begin
      phase_nxt = ~phase_r;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      count_r <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  assign trig_level = phase_r;

endmodule
